/* rtl/dlpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlpd_pkg
// shared types and constants of the decimal length-prefix deframer
// ----------------------------------------------------------------------------
package dlpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 14;

  localparam logic [LenW-1:0]  LenMax    = {LenW{1'b1}};
  localparam logic [ByteW-1:0] AsciiZero = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine = 8'h39;

  // one result item
  typedef struct packed {
    logic [ByteW-1:0] body_byte;
    logic             first_of_message;
    logic             last_of_message;
    logic             empty_message;
    logic             header_error;
  } res_t;

endpackage : dlpd_pkg
`default_nettype wire

/* rtl/decimal_length_prefix_deframer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_length_prefix_deframer_core
// splits a byte stream framed by fixed-width ascii decimal length headers
// ----------------------------------------------------------------------------
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid_i, in_ready_o, in_byte_i              | in
//  out     | out_valid_o, out_ready_i, body_byte_o,         | out
//          | first_of_message_o, last_of_message_o,         |
//          | empty_message_o, header_error_o                |
//
//  one byte per cycle while in_ready_o is high: each input transfer updates
//  the parse state and loads any result into the output register at that edge
//  reset clears the parse state and the output valid flag
//  in_ready_o is high while the output register is empty or being drained,
//  so a stalled output holds the stream after one pending result
// ----------------------------------------------------------------------------
module decimal_length_prefix_deframer_core import dlpd_pkg::*; #(
  parameter int unsigned HEAD_DIGITS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] body_byte_o,
  output logic             first_of_message_o,
  output logic             last_of_message_o,
  output logic             empty_message_o,
  output logic             header_error_o
);

  localparam int unsigned CntW = $clog2(HEAD_DIGITS + 1);

  // parse state
  logic            in_body_q, in_body_d;
  logic [CntW-1:0] digits_seen_q, digits_seen_d;
  logic [LenW-1:0] length_accum_q, length_accum_d;
  logic [LenW-1:0] body_remaining_q, body_remaining_d;
  logic            at_body_start_q, at_body_start_d;

  // output register
  logic out_valid_q;
  res_t res_q;
  res_t step_res;
  logic step_emit;
  logic in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  dlpd_step #(
    .HEAD_DIGITS(HEAD_DIGITS),
    .CntW       (CntW)
  ) u_step (
    .in_byte_i       (in_byte_i),
    .in_body_i       (in_body_q),
    .digits_seen_i   (digits_seen_q),
    .length_accum_i  (length_accum_q),
    .body_remaining_i(body_remaining_q),
    .at_body_start_i (at_body_start_q),
    .in_body_o       (in_body_d),
    .digits_seen_o   (digits_seen_d),
    .length_accum_o  (length_accum_d),
    .body_remaining_o(body_remaining_d),
    .at_body_start_o (at_body_start_d),
    .emit_o          (step_emit),
    .res_o           (step_res)
  );

  // state advances only on an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q        <= 1'b0;
      digits_seen_q    <= '0;
      length_accum_q   <= '0;
      body_remaining_q <= '0;
      at_body_start_q  <= 1'b0;
    end else if (in_xfer) begin
      in_body_q        <= in_body_d;
      digits_seen_q    <= digits_seen_d;
      length_accum_q   <= length_accum_d;
      body_remaining_q <= body_remaining_d;
      at_body_start_q  <= at_body_start_d;
    end
  end

  // result register: refilled on a transfer that yields a result, cleared when drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_xfer && step_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && step_emit) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign body_byte_o        = res_q.body_byte;
  assign first_of_message_o = res_q.first_of_message;
  assign last_of_message_o  = res_q.last_of_message;
  assign empty_message_o    = res_q.empty_message;
  assign header_error_o     = res_q.header_error;

endmodule : decimal_length_prefix_deframer_core
`default_nettype wire

/* rtl/dlpd_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlpd_step
// next-state and result logic for one stream byte
// ----------------------------------------------------------------------------
module dlpd_step import dlpd_pkg::*; #(
  parameter int unsigned HEAD_DIGITS = 4,
  parameter int unsigned CntW        = $clog2(HEAD_DIGITS + 1)
) (
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_body_i,
  input  logic [CntW-1:0]  digits_seen_i,
  input  logic [LenW-1:0]  length_accum_i,
  input  logic [LenW-1:0]  body_remaining_i,
  input  logic             at_body_start_i,
  output logic             in_body_o,
  output logic [CntW-1:0]  digits_seen_o,
  output logic [LenW-1:0]  length_accum_o,
  output logic [LenW-1:0]  body_remaining_o,
  output logic             at_body_start_o,
  output logic             emit_o,
  output res_t             res_o
);

  localparam int unsigned MulW = LenW + 4;
  localparam logic [CntW-1:0] DigitsLast = CntW'(HEAD_DIGITS);

  logic            is_digit;
  logic [MulW-1:0] acc_x10;
  logic [LenW-1:0] acc_sat;
  logic [LenW-1:0] rem_dec;
  logic [CntW-1:0] cnt_inc;

  assign is_digit = (in_byte_i >= AsciiZero) && (in_byte_i <= AsciiNine);
  // acc*10 + digit as two shifts and adds
  assign acc_x10  = {1'b0, length_accum_i, 3'b000} + {3'b000, length_accum_i, 1'b0}
                  + MulW'(in_byte_i - AsciiZero);
  assign acc_sat  = (|acc_x10[MulW-1:LenW]) ? LenMax : acc_x10[LenW-1:0];
  assign rem_dec  = (body_remaining_i != '0) ? body_remaining_i - 1'b1
                                             : body_remaining_i;
  assign cnt_inc  = digits_seen_i + 1'b1;

  always_comb begin
    in_body_o        = in_body_i;
    digits_seen_o    = digits_seen_i;
    length_accum_o   = length_accum_i;
    body_remaining_o = body_remaining_i;
    at_body_start_o  = at_body_start_i;
    emit_o           = 1'b0;
    res_o            = '0;
    if (in_body_i) begin
      emit_o                 = 1'b1;
      at_body_start_o        = 1'b0;
      body_remaining_o       = rem_dec;
      res_o.body_byte        = in_byte_i;
      res_o.first_of_message = at_body_start_i;
      res_o.last_of_message  = (rem_dec == '0);
      if (rem_dec == '0) begin
        in_body_o = 1'b0;
      end
    end else if (!is_digit) begin
      digits_seen_o      = '0;
      length_accum_o     = '0;
      emit_o             = 1'b1;
      res_o.header_error = 1'b1;
    end else if (cnt_inc < DigitsLast) begin
      digits_seen_o  = cnt_inc;
      length_accum_o = acc_sat;
    end else begin
      digits_seen_o = '0;
      if (acc_sat == '0) begin
        length_accum_o        = '0;
        emit_o                = 1'b1;
        res_o.empty_message   = 1'b1;
        res_o.last_of_message = 1'b1;
      end else begin
        body_remaining_o = acc_sat;
        length_accum_o   = '0;
        in_body_o        = 1'b1;
        at_body_start_o  = 1'b1;
      end
    end
  end

endmodule : dlpd_step
`default_nettype wire

/* tb/sv/dlpd_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dlpd_tb_pkg
// scoreboard for the deframer bench: tracks the framing state of the byte
// stream and keeps the results that are still owed by the block
// ----------------------------------------------------------------------------
package dlpd_tb_pkg;

  import dlpd_pkg::*;

  class deframe_tracker;
    int unsigned      head_digits;
    logic             in_body;
    logic [3:0]       digits_seen;
    logic [LenW-1:0]  length_accum;
    logic [LenW-1:0]  body_remaining;
    logic             at_body_start;
    res_t             pending_results[$];
    int unsigned      mismatch_count;

    function new(int unsigned digits);
      head_digits    = digits;
      in_body        = 1'b0;
      digits_seen    = '0;
      length_accum   = '0;
      body_remaining = '0;
      at_body_start  = 1'b0;
      mismatch_count = 0;
    endfunction

    // true while part of a header has been taken
    function bit mid_header();
      return !in_body && digits_seen != 0;
    endfunction

    // advance the framing state by one accepted byte
    function void take_byte(logic [ByteW-1:0] b);
      res_t        r;
      int unsigned grown;
      r = '0;
      if (in_body) begin
        r.body_byte        = b;
        r.first_of_message = at_body_start;
        at_body_start      = 1'b0;
        if (body_remaining != 0) body_remaining--;
        r.last_of_message = (body_remaining == 0);
        if (r.last_of_message) in_body = 1'b0;
        pending_results.push_back(r);
        return;
      end
      if (b < AsciiZero || b > AsciiNine) begin
        digits_seen    = '0;
        length_accum   = '0;
        r.header_error = 1'b1;
        pending_results.push_back(r);
        return;
      end
      grown = int'(length_accum) * 10 + int'(b - AsciiZero);
      length_accum = (grown > int'(LenMax)) ? LenMax : grown[LenW-1:0];
      digits_seen++;
      if (digits_seen < head_digits) return;
      digits_seen = '0;
      if (length_accum == 0) begin
        r.last_of_message = 1'b1;
        r.empty_message   = 1'b1;
        pending_results.push_back(r);
        return;
      end
      body_remaining = length_accum;
      length_accum   = '0;
      in_body        = 1'b1;
      at_body_start  = 1'b1;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatch_count++;
      end
    endfunction

    // compare one output transfer with the oldest owed result
    function void match_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: body_byte %0h", got.body_byte);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      check_field("body_byte", want.body_byte, got.body_byte);
      check_field("first_of_message", want.first_of_message, got.first_of_message);
      check_field("last_of_message", want.last_of_message, got.last_of_message);
      check_field("empty_message", want.empty_message, got.empty_message);
      check_field("header_error", want.header_error, got.header_error);
    endfunction
  endclass

endpackage : dlpd_tb_pkg

/* tb/sv/decimal_length_prefix_deframer_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_length_prefix_deframer_core_tb
// drives framed byte streams (clean frames, cut headers, stray bytes) into
// the deframer under random sender gaps and receiver stalls, and checks
// every output transfer against a tracker
// ----------------------------------------------------------------------------
module decimal_length_prefix_deframer_core_tb;

  import dlpd_pkg::*;
  import dlpd_tb_pkg::*;

  localparam int unsigned HeadDigits  = 4;
  localparam int unsigned RandomBytes = 600;

  typedef enum logic [1:0] {
    SinkOpen,
    SinkCoin,
    SinkBursty
  } sink_mode_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [ByteW-1:0] in_byte_i   = '0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [ByteW-1:0] body_byte_o;
  logic             first_of_message_o;
  logic             last_of_message_o;
  logic             empty_message_o;
  logic             header_error_o;

  deframe_tracker tracker = new(HeadDigits);

  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;

  decimal_length_prefix_deframer_core #(
    .HEAD_DIGITS(HeadDigits)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_byte_i          (in_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .body_byte_o        (body_byte_o),
    .first_of_message_o (first_of_message_o),
    .last_of_message_o  (last_of_message_o),
    .empty_message_o    (empty_message_o),
    .header_error_o     (header_error_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // one input transfer; entered and left at a falling edge. valid is only
  // dropped when a gap opens, so back-to-back bytes keep it high
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.take_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // ascii decimal header, most significant digit first
  task automatic send_header(input int unsigned len);
    int unsigned div;
    div = 1;
    repeat (HeadDigits - 1) div *= 10;
    repeat (HeadDigits) begin
      send_byte(AsciiZero + ByteW'((len / div) % 10));
      div /= 10;
    end
  endtask

  task automatic send_frame(input int unsigned len);
    send_header(len);
    repeat (len) send_byte(ByteW'($urandom_range(0, 255)));
  endtask

  function automatic logic [ByteW-1:0] pick_non_digit();
    if ($urandom_range(0, 1) == 0) return ByteW'($urandom_range(0, AsciiZero - 1));
    return ByteW'($urandom_range(AsciiNine + 1, 255));
  endfunction

  // hold the stream until the block owes nothing
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: stall pattern switches mode every so often
  // ---------------------------------------------------------------------------
  sink_mode_e  sink_mode  = SinkOpen;
  int unsigned mode_left  = 100;
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin
    logic ready_next;
    if (mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(50, 200);
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else begin
      case (sink_mode)
        SinkOpen: ready_next = 1'b1;
        SinkCoin: ready_next = 1'($urandom_range(0, 1));
        default: begin
          // mostly open with an occasional long stall
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 10);
            ready_next = 1'b0;
          end else begin
            ready_next = 1'b1;
          end
        end
      endcase
    end
    out_ready_i <= ready_next;
  end

  // ---------------------------------------------------------------------------
  // output transfers go straight to the scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.body_byte        = body_byte_o;
      got.first_of_message = first_of_message_o;
      got.last_of_message  = last_of_message_o;
      got.empty_message    = empty_message_o;
      got.header_error     = header_error_o;
      tracker.match_result(got);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned start_count;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero length, bytes just outside the digit range, extremes
    send_frame(0);
    send_byte(AsciiZero - 8'd1);
    send_byte(AsciiNine + 8'd1);
    send_byte(8'h00);
    send_byte(8'hFF);
    // header cut short by a non-digit
    send_byte("1");
    send_byte("2");
    send_byte("x");
    // one-byte body: first and last on the same transfer
    send_header(1);
    send_byte(8'h00);
    // body bytes that look like digits or junk pass through untouched
    send_header(3);
    send_byte(8'hFF);
    send_byte(AsciiNine);
    send_byte(AsciiZero - 8'd1);

    // hold the sender until the block is empty
    drain_results();

    // random: mostly clean frames, some cut headers and stray bytes
    start_count = bytes_sent;
    while (bytes_sent - start_count < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = $urandom_range(0, 9);
        if (len == 0) len = 0;
        else if (len < 8) len = $urandom_range(1, 16);
        else len = $urandom_range(17, 300);
        send_frame(len);
      end else if (pick < 92) begin
        repeat ($urandom_range(0, HeadDigits - 1)) send_byte(AsciiZero + ByteW'($urandom_range(0, 9)));
        send_byte(pick_non_digit());
      end else begin
        send_byte(ByteW'($urandom_range(0, 255)));
      end
      // a stray digit leaves a partial header; resync so frames stay short
      if (tracker.mid_header()) send_byte(pick_non_digit());
    end

    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule : decimal_length_prefix_deframer_core_tb
